FILE: rtl/assert_macros.svh
// Assertion macros shared by the hashed duplicate filter RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

FILE: rtl/hdf_pkg.sv
// Package for the hashed duplicate filter: widths, defaults and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package hdf_pkg;

    localparam int unsigned HashW         = 32;
    localparam int unsigned DefNumBuckets = 256;
    localparam int unsigned DefBucketCap  = 16;

    typedef struct packed {
        logic clr_step;
        logic load_hash;
        logic mod_step;
        logic srch_init;
        logic probe;
        logic cmp;
        logic decide;
        logic shift;
        logic insert;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic srch_done;
        logic found;
        logic full;
        logic at_pos;
        logic shift_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/hdf_if.sv
// Valid/ready channel interfaces of the hashed duplicate filter.
// Depends on hdf_pkg.
`default_nettype none

interface hdf_in_if import hdf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [HashW-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface hdf_out_if;
    logic valid;
    logic ready;
    logic is_new;
    logic overflow;

    modport source (output valid, output is_new, output overflow, input ready);
    modport sink   (input valid, input is_new, input overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/hashed_duplicate_filter.sv
// Per transaction: bucket select (mask, or reciprocal multiply when NUM_BUCKETS is not a
// power of two), count read, binary search of at most ceil(log2(BUCKET_CAPACITY+1)) probes,
// then for a new hash in a bucket that is not full, a shift of fewer than capacity entries
// and an insert. One transaction at a time: the next is taken in the cycle after the result
// loads, and a waiting result stalls it. Reset: synchronous, active low; bucket counts clear
// after reset, input not ready then. Depends on hdf_pkg, hdf_if, hdf_ctrl and hdf_datapath.
`default_nettype none

module hashed_duplicate_filter import hdf_pkg::*; #(
    parameter int unsigned NUM_BUCKETS     = DefNumBuckets,
    parameter int unsigned BUCKET_CAPACITY = DefBucketCap
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    hdf_in_if.sink     i_in,
    hdf_out_if.source  o_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    hdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    hdf_datapath #(
        .NUM_BUCKETS     (NUM_BUCKETS),
        .BUCKET_CAPACITY (BUCKET_CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_hash_value (i_in.hash_value),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_is_new     (o_out.is_new),
        .o_overflow   (o_out.overflow)
    );

endmodule

`default_nettype wire

FILE: rtl/hdf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module hdf_ram #(
    parameter int unsigned W     = 32,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/hdf_ctrl.sv
// Controller state machine of the hashed duplicate filter.
// Depends on hdf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hdf_ctrl import hdf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_MOD    = 4'd2;
    localparam logic [3:0] S_CNT    = 4'd3;
    localparam logic [3:0] S_CNTW   = 4'd4;
    localparam logic [3:0] S_PROBE  = 4'd5;
    localparam logic [3:0] S_CMP    = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_SHIFT  = 4'd8;
    localparam logic [3:0] S_INSERT = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_hash = 1'b1;
                    n_state         = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = S_CNT;
                end
            end
            S_CNT: begin
                n_state = S_CNTW;
            end
            S_CNTW: begin
                o_cmd.srch_init = 1'b1;
                n_state         = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.srch_done) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_PROBE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.found || i_sts.full) begin
                    n_state = S_DONE;
                end else if (i_sts.at_pos) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEVER(a_insert_ok, i_clk, i_rst_n,
        (r_state == S_INSERT) && (i_sts.full || i_sts.found),
        "insert into full bucket or over a match")
    `ASSERT_NEVER(a_shift_pos, i_clk, i_rst_n,
        (r_state == S_SHIFT) && i_sts.at_pos,
        "shift with insert position at list end")
    `ASSERT_CLK(a_accept_mod, i_clk, i_rst_n,
        ((r_state == S_IDLE) && i_in_valid) |=> (r_state == S_MOD),
        "accepted transaction not followed by bucket select")

endmodule

`default_nettype wire

FILE: rtl/hdf_datapath.sv
// Datapath of the hashed duplicate filter: bucket remainder, count and entry
// RAMs, binary search, insertion shift and output register.
// Depends on hdf_pkg, hdf_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hdf_datapath import hdf_pkg::*; #(
    parameter int unsigned NUM_BUCKETS     = DefNumBuckets,
    parameter int unsigned BUCKET_CAPACITY = DefBucketCap
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    input  wire logic [HashW-1:0] i_hash_value,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_is_new,
    output logic                  o_overflow
);

    localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int unsigned CW    = $clog2(BUCKET_CAPACITY + 1);
    localparam int unsigned IW    = (BUCKET_CAPACITY > 1) ? $clog2(BUCKET_CAPACITY) : 1;
    localparam int unsigned Depth = NUM_BUCKETS * BUCKET_CAPACITY;
    localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

    localparam logic [CW-1:0] CapC       = CW'(BUCKET_CAPACITY);
    localparam logic [BW-1:0] LastBucket = BW'(NUM_BUCKETS - 1);

    logic [HashW-1:0] r_hash;
    logic [BW-1:0]    r_bucket;
    logic [AW-1:0]    r_base;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_lo;
    logic [CW-1:0]    r_hi;
    logic [IW-1:0]    r_mid;
    logic             r_eq;
    logic [IW-1:0]    r_wr_idx;
    logic             r_res_new;
    logic             r_res_ovf;
    logic [BW-1:0]    r_clr_addr;
    logic             r_out_valid;
    logic             r_out_new;
    logic             r_out_ovf;

    logic             w_mod_done;
    logic [CW-1:0]    w_mid;
    logic [IW-1:0]    w_rd_idx;
    logic [IW-1:0]    w_wr_idx;
    logic [AW-1:0]    w_ent_raddr;
    logic [AW-1:0]    w_ent_waddr;
    logic [HashW-1:0] w_ent_wdata;
    logic [HashW-1:0] w_ent_rd;
    logic             w_ent_we;
    logic             w_cnt_we;
    logic [BW-1:0]    w_cnt_waddr;
    logic [CW-1:0]    w_cnt_wdata;
    logic [CW-1:0]    w_cnt_rd;

    // bucket = hash mod NUM_BUCKETS
    if ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0) begin : g_mod_mask
        localparam logic [HashW-1:0] HashMask = HashW'(NUM_BUCKETS - 1);

        always_ff @(posedge i_clk) begin
            if (i_cmd.mod_step) begin
                r_bucket <= BW'(r_hash & HashMask);
            end
        end
        assign w_mod_done = 1'b1;
    end else begin : g_mod_recip
        // quotient = (hash * Recip) >> RecipSh, exact for every 32-bit hash;
        // four steps: low half product, high half product, shift, remainder
        localparam int unsigned RecipSh = HashW + $clog2(NUM_BUCKETS);
        localparam logic [63:0] RecipW  = ((64'd1 << RecipSh) / 64'(NUM_BUCKETS)) + 64'd1;
        localparam logic [33:0] Recip   = RecipW[33:0];

        logic [1:0]       r_mod_cnt;
        logic [65:0]      r_prod;
        logic [HashW-1:0] r_quot;
        logic [15:0]      w_half;
        logic [49:0]      w_part;
        logic [HashW-1:0] w_qm;

        assign w_half = (r_mod_cnt == 2'd0) ? r_hash[15:0] : r_hash[31:16];
        assign w_part = 50'(w_half) * 50'(Recip);
        assign w_qm   = r_quot * HashW'(NUM_BUCKETS);

        always_ff @(posedge i_clk) begin
            if (i_cmd.load_hash) begin
                r_mod_cnt <= '0;
            end else if (i_cmd.mod_step) begin
                r_mod_cnt <= r_mod_cnt + 2'd1;
                case (r_mod_cnt)
                    2'd0: r_prod   <= 66'(w_part);
                    2'd1: r_prod   <= r_prod + {w_part, 16'd0};
                    2'd2: r_quot   <= HashW'(r_prod >> RecipSh);
                    2'd3: r_bucket <= BW'(r_hash - w_qm);
                endcase
            end
        end
        assign w_mod_done = (r_mod_cnt == 2'd3);
    end

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        w_rd_idx = w_mid[IW-1:0];
        if (i_cmd.decide) begin
            w_rd_idx = r_cnt[IW-1:0] - IW'(1);
        end else if (i_cmd.shift) begin
            w_rd_idx = r_wr_idx - IW'(2);
        end
    end

    assign w_wr_idx    = i_cmd.shift ? r_wr_idx : r_lo[IW-1:0];
    assign w_ent_raddr = r_base + AW'(w_rd_idx);
    assign w_ent_waddr = r_base + AW'(w_wr_idx);
    assign w_ent_we    = i_cmd.shift || i_cmd.insert;
    assign w_ent_wdata = i_cmd.insert ? r_hash : w_ent_rd;

    assign w_cnt_we    = i_cmd.clr_step || i_cmd.insert;
    assign w_cnt_waddr = i_cmd.clr_step ? r_clr_addr : r_bucket;
    assign w_cnt_wdata = i_cmd.clr_step ? '0 : r_cnt + CW'(1);

    hdf_ram #(
        .W     (HashW),
        .DEPTH (Depth)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_ent_waddr),
        .i_wdata (w_ent_wdata),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rd)
    );

    hdf_ram #(
        .W     (CW),
        .DEPTH (NUM_BUCKETS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_raddr (r_bucket),
        .o_rdata (w_cnt_rd)
    );

    always_ff @(posedge i_clk) begin
        r_base <= AW'(32'(r_bucket) * 32'(BUCKET_CAPACITY));

        if (i_cmd.load_hash) begin
            r_hash <= i_hash_value;
        end

        if (i_cmd.srch_init) begin
            r_cnt <= w_cnt_rd;
            r_lo  <= '0;
            r_hi  <= w_cnt_rd;
            r_eq  <= 1'b0;
        end else if (i_cmd.cmp) begin
            if (w_ent_rd < r_hash) begin
                r_lo <= CW'(r_mid) + CW'(1);
            end else begin
                r_hi <= CW'(r_mid);
                r_eq <= (w_ent_rd == r_hash);
            end
        end

        if (i_cmd.probe) begin
            r_mid <= w_mid[IW-1:0];
        end

        if (i_cmd.decide) begin
            r_res_new <= !r_eq;
            r_res_ovf <= !r_eq && (r_cnt == CapC);
            r_wr_idx  <= r_cnt[IW-1:0];
        end else if (i_cmd.shift) begin
            r_wr_idx  <= r_wr_idx - IW'(1);
        end

        if (i_cmd.load_out) begin
            r_out_new <= r_res_new;
            r_out_ovf <= r_res_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + BW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = (r_clr_addr == LastBucket);
        o_sts.mod_done   = w_mod_done;
        o_sts.srch_done  = (r_lo == r_hi);
        o_sts.found      = r_eq;
        o_sts.full       = (r_cnt == CapC);
        o_sts.at_pos     = (r_lo == r_cnt);
        o_sts.shift_last = ((r_wr_idx - IW'(1)) == r_lo[IW-1:0]);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_is_new    = r_out_new;
    assign o_overflow  = r_out_ovf;

    `ASSERT_CLK(a_search_order, i_clk, i_rst_n,
        i_cmd.cmp |=> (r_lo <= r_hi),
        "search bounds crossed")
    `ASSERT_NEVER(a_ovf_is_new, i_clk, i_rst_n,
        r_out_valid && r_out_ovf && !r_out_new,
        "overflow on a duplicate")
    `ASSERT_NEVER(a_cnt_limit, i_clk, i_rst_n,
        i_cmd.insert && (r_cnt >= CapC),
        "insert beyond capacity")

endmodule

`default_nettype wire
